// ----- rtl/core/row_shared_exclusive_lock_queue_top_defines.svh -----
// ----------------------------------------------------------------------------
// Row lock queue assertion macros
// Shared assertion forms for the lock queue controller and datapath.
// ----------------------------------------------------------------------------
`ifndef ROW_SHARED_EXCLUSIVE_LOCK_QUEUE_TOP_DEFINES_SVH
`define ROW_SHARED_EXCLUSIVE_LOCK_QUEUE_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define RSELQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define RSELQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/rselq_pkg.sv -----
// ----------------------------------------------------------------------------
// Row lock queue package
// Beat types, codes and controller/datapath interface structs.
// ----------------------------------------------------------------------------
`default_nettype none

package rselq_pkg;

  localparam logic OP_ACQUIRE = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  localparam logic [2:0] ST_GRANTED    = 3'd0;
  localparam logic [2:0] ST_QUEUED     = 3'd1;
  localparam logic [2:0] ST_ABORTED    = 3'd2;
  localparam logic [2:0] ST_RELEASED   = 3'd3;
  localparam logic [2:0] ST_GRANTED_Q  = 3'd4;
  localparam logic [2:0] ST_NOT_HELD   = 3'd5;
  localparam logic [2:0] ST_TABLE_FULL = 3'd6;

  localparam logic [1:0] MODE_NONE = 2'd0;
  localparam logic [1:0] MODE_SH   = 2'd1;
  localparam logic [1:0] MODE_EX   = 2'd2;

  typedef struct packed {
    logic        opcode;
    logic [15:0] txn_id;
    logic        lock_kind;
    logic        queue_on_conflict;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] result_txn;
    logic        result_kind;
    logic [4:0]  holder_count;
    logic [4:0]  queued_count;
    logic        last;
  } rsp_t;

  typedef struct packed {
    logic load;
    logic acq;
    logic hs_step;
    logic ws_step;
    logic grant;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic is_release;
    logic hit_h;
    logic ptr_zero;
    logic hit_w;
    logic ws_end;
    logic grant_ok;
  } stat_t;

  function automatic logic conflicts(logic [1:0] mode, logic kind);
    return (mode != MODE_NONE) && ((mode == MODE_EX) || kind);
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/row_shared_exclusive_lock_queue_top.sv -----
// ----------------------------------------------------------------------------
// Row shared/exclusive lock queue
// Lock manager for one row with an owner table and a FIFO of waiters.
// ----------------------------------------------------------------------------
//  channel   handshake         payload
//  request   start / busy      req    (rselq_pkg::req_t)
//  result    strobe, 1 cycle   rsp    (rselq_pkg::rsp_t)
//
// An acquire goes through decode and the acquire step before its result beat.
// A release scans the H owner entries newest first, then the W waiters, one
// entry per step through the single compare port on each table; a hit ends
// the scan early. Each granted waiter then adds a grant step and a beat.
// Synchronous reset empties both tables; no clearing pass is needed.
// The receiver cannot stall; busy stays high until the last beat is issued.
// ----------------------------------------------------------------------------
`default_nettype none

module row_shared_exclusive_lock_queue_top #(
  parameter int MAX_HOLDERS = 16,
  parameter int MAX_WAITERS = 16,
  parameter int TXN_ID_BITS = 16
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire rselq_pkg::req_t req,
  output logic                 busy,
  output logic                 strobe,
  output rselq_pkg::rsp_t      rsp
);

  rselq_pkg::cmd_t  cmd;
  rselq_pkg::stat_t stat;

  rselq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .busy  (busy),
    .cmd   (cmd)
  );

  rselq_dp #(
    .MAX_HOLDERS (MAX_HOLDERS),
    .MAX_WAITERS (MAX_WAITERS),
    .TXN_ID_BITS (TXN_ID_BITS)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .cmd    (cmd),
    .stat   (stat),
    .strobe (strobe),
    .rsp    (rsp)
  );

endmodule

`default_nettype wire

// ----- rtl/core/rselq_dp.sv -----
// ----------------------------------------------------------------------------
// Row lock queue datapath
// Owner table, waiter FIFO, search pointer, pending result and output beat.
// ----------------------------------------------------------------------------
`default_nettype none

module rselq_dp #(
  parameter int MAX_HOLDERS = 16,
  parameter int MAX_WAITERS = 16,
  parameter int TXN_ID_BITS = 16
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire rselq_pkg::req_t req,
  input  wire rselq_pkg::cmd_t cmd,
  output rselq_pkg::stat_t    stat,
  output logic                strobe,
  output rselq_pkg::rsp_t     rsp
);

  localparam int IDW = (TXN_ID_BITS < 16) ? TXN_ID_BITS : 16;
  localparam int HCW = $clog2(MAX_HOLDERS + 1);
  localparam int WCW = $clog2(MAX_WAITERS + 1);
  localparam int HIW = (MAX_HOLDERS > 1) ? $clog2(MAX_HOLDERS) : 1;
  localparam int WIW = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1;
  localparam int MAXQ = (MAX_HOLDERS > MAX_WAITERS) ? MAX_HOLDERS : MAX_WAITERS;
  localparam int PW  = $clog2(MAXQ + 1);

  logic [IDW-1:0] holder_ids [MAX_HOLDERS];
  logic           holder_kinds [MAX_HOLDERS];
  logic [IDW-1:0] waiter_ids [MAX_WAITERS];
  logic           waiter_kinds [MAX_WAITERS];
  logic [HCW-1:0] holder_total;
  logic [WCW-1:0] waiter_total;
  logic [1:0]     mode;
  logic [PW-1:0]  ptr;

  logic           op;
  logic [IDW-1:0] txn;
  logic           kind;
  logic           qmode;

  logic [2:0]     pend_status;
  logic [IDW-1:0] pend_txn;
  logic           pend_kind;

  logic [PW-1:0]  ptr_m1;
  logic [HIW-1:0] rem_h;
  logic [WIW-1:0] rem_w;
  logic           h_full;
  logic           w_full;
  logic           acq_conf;
  logic           acq_hold;
  logic           acq_wait;
  logic           do_rem_h;
  logic           do_rem_w;

  assign ptr_m1 = ptr - PW'(1);
  assign rem_h  = ptr_m1[HIW-1:0];
  assign rem_w  = ptr[WIW-1:0];
  assign h_full = (holder_total == HCW'(MAX_HOLDERS));
  assign w_full = (waiter_total == WCW'(MAX_WAITERS));

  assign stat.is_release = (op == rselq_pkg::OP_RELEASE);
  assign stat.ptr_zero   = (ptr == '0);
  assign stat.hit_h      = (ptr != '0) && (holder_ids[rem_h] == txn);
  assign stat.ws_end     = (ptr >= PW'(waiter_total));
  assign stat.hit_w      = !stat.ws_end && (waiter_ids[rem_w] == txn);
  assign stat.grant_ok   = (waiter_total != '0) && !h_full &&
                           !rselq_pkg::conflicts(mode, waiter_kinds[0]);

  assign acq_conf = rselq_pkg::conflicts(mode, kind) || (qmode && (waiter_total != '0));
  assign acq_hold = cmd.acq && !acq_conf && !h_full;
  assign acq_wait = cmd.acq && acq_conf && qmode && !w_full;
  assign do_rem_h = cmd.hs_step && stat.hit_h;
  assign do_rem_w = cmd.ws_step && stat.hit_w;

  // Table contents carry no reset; only entries below the totals are read.
  always_ff @(posedge clk) begin
    if (do_rem_h) begin
      for (int j = 0; j < MAX_HOLDERS - 1; j++) begin
        if (j >= int'(rem_h)) begin
          holder_ids[j]   <= holder_ids[j+1];
          holder_kinds[j] <= holder_kinds[j+1];
        end
      end
    end
    if (acq_hold) begin
      holder_ids[holder_total[HIW-1:0]]   <= txn;
      holder_kinds[holder_total[HIW-1:0]] <= kind;
    end
    if (cmd.grant) begin
      holder_ids[holder_total[HIW-1:0]]   <= waiter_ids[0];
      holder_kinds[holder_total[HIW-1:0]] <= waiter_kinds[0];
    end
    if (do_rem_w || cmd.grant) begin
      for (int j = 0; j < MAX_WAITERS - 1; j++) begin
        if (cmd.grant || (j >= int'(rem_w))) begin
          waiter_ids[j]   <= waiter_ids[j+1];
          waiter_kinds[j] <= waiter_kinds[j+1];
        end
      end
    end
    if (acq_wait) begin
      waiter_ids[waiter_total[WIW-1:0]]   <= txn;
      waiter_kinds[waiter_total[WIW-1:0]] <= kind;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      holder_total <= '0;
      waiter_total <= '0;
      mode         <= rselq_pkg::MODE_NONE;
      ptr          <= '0;
      strobe       <= 1'b0;
    end else begin
      strobe <= cmd.emit;
      if (cmd.load) begin
        ptr <= PW'(holder_total);
      end
      if (acq_hold) begin
        holder_total <= holder_total + HCW'(1);
        mode         <= kind ? rselq_pkg::MODE_EX : rselq_pkg::MODE_SH;
      end
      if (acq_wait) begin
        waiter_total <= waiter_total + WCW'(1);
      end
      if (cmd.hs_step) begin
        if (stat.hit_h) begin
          holder_total <= holder_total - HCW'(1);
          if (holder_total == HCW'(1)) begin
            mode <= rselq_pkg::MODE_NONE;
          end
        end else if (!stat.ptr_zero) begin
          ptr <= ptr_m1;
        end
      end
      if (cmd.ws_step) begin
        if (stat.hit_w) begin
          waiter_total <= waiter_total - WCW'(1);
        end else if (!stat.ws_end) begin
          ptr <= ptr + PW'(1);
        end
      end
      if (cmd.grant) begin
        waiter_total <= waiter_total - WCW'(1);
        holder_total <= holder_total + HCW'(1);
        mode         <= waiter_kinds[0] ? rselq_pkg::MODE_EX : rselq_pkg::MODE_SH;
      end
    end
  end

  // Input item, pending result and output beat registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op          <= req.opcode;
      txn         <= req.txn_id[IDW-1:0];
      kind        <= req.lock_kind;
      qmode       <= req.queue_on_conflict;
      pend_txn    <= req.txn_id[IDW-1:0];
      pend_status <= rselq_pkg::ST_NOT_HELD;
      pend_kind   <= 1'b0;
    end
    if (cmd.acq) begin
      pend_kind <= kind;
      priority if (acq_hold) begin
        pend_status <= rselq_pkg::ST_GRANTED;
      end else if (acq_wait) begin
        pend_status <= rselq_pkg::ST_QUEUED;
      end else if (acq_conf && !qmode) begin
        pend_status <= rselq_pkg::ST_ABORTED;
      end else begin
        pend_status <= rselq_pkg::ST_TABLE_FULL;
      end
    end
    if (do_rem_h) begin
      pend_status <= rselq_pkg::ST_RELEASED;
      pend_kind   <= holder_kinds[rem_h];
    end
    if (do_rem_w) begin
      pend_status <= rselq_pkg::ST_RELEASED;
      pend_kind   <= waiter_kinds[rem_w];
    end
    if (cmd.grant) begin
      pend_status <= rselq_pkg::ST_GRANTED_Q;
      pend_txn    <= waiter_ids[0];
      pend_kind   <= waiter_kinds[0];
    end
    if (cmd.emit) begin
      rsp.status       <= pend_status;
      rsp.result_txn   <= 16'(pend_txn);
      rsp.result_kind  <= pend_kind;
      rsp.holder_count <= 5'(holder_total);
      rsp.queued_count <= 5'(waiter_total);
      rsp.last         <= !stat.is_release || !stat.grant_ok;
    end
  end

`include "row_shared_exclusive_lock_queue_top_defines.svh"

  `RSELQ_ASSERT_NOW(a_holder_bound, 1'b1, holder_total <= HCW'(MAX_HOLDERS), "owner count over limit")
  `RSELQ_ASSERT_NOW(a_waiter_bound, 1'b1, waiter_total <= WCW'(MAX_WAITERS), "waiter count over limit")
  `RSELQ_ASSERT_NOW(a_mode_empty, 1'b1, (mode == rselq_pkg::MODE_NONE) == (holder_total == '0), "mode disagrees with owner count")
  `RSELQ_ASSERT_NOW(a_grant_legal, cmd.grant, stat.grant_ok, "grant issued without a compatible head waiter")

endmodule

`default_nettype wire

// ----- rtl/core/rselq_ctrl.sv -----
// ----------------------------------------------------------------------------
// Row lock queue controller
// Sequences acquire, release search and the grant run over the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module rselq_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire rselq_pkg::stat_t stat,
  output logic                 busy,
  output rselq_pkg::cmd_t      cmd
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_DEC   = 7'b0000010,
    S_ACQ   = 7'b0000100,
    S_HSRCH = 7'b0001000,
    S_WSRCH = 7'b0010000,
    S_EMIT  = 7'b0100000,
    S_GRANT = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_DEC;
        end
      end
      S_DEC: begin
        state_next = stat.is_release ? S_HSRCH : S_ACQ;
      end
      S_ACQ: begin
        cmd.acq    = 1'b1;
        state_next = S_EMIT;
      end
      S_HSRCH: begin
        cmd.hs_step = 1'b1;
        if (stat.hit_h) begin
          state_next = S_EMIT;
        end else if (stat.ptr_zero) begin
          state_next = S_WSRCH;
        end
      end
      S_WSRCH: begin
        cmd.ws_step = 1'b1;
        if (stat.hit_w || stat.ws_end) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        cmd.emit   = 1'b1;
        state_next = (stat.is_release && stat.grant_ok) ? S_GRANT : S_IDLE;
      end
      S_GRANT: begin
        cmd.grant  = 1'b1;
        state_next = S_EMIT;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

`include "row_shared_exclusive_lock_queue_top_defines.svh"

  `RSELQ_ASSERT_NOW(a_state_onehot, 1'b1, $onehot(state), "controller state not one-hot")
  `RSELQ_ASSERT_NXT(a_accept_dec, start && !busy, state == S_DEC, "accepted item did not reach decode")
  `RSELQ_ASSERT_NXT(a_grant_emit, state == S_GRANT, state == S_EMIT, "grant not followed by a result")

endmodule

`default_nettype wire
